@@ rtl/core/ipd_pkg.sv @@
// ----------------------------------------------------------------------------
// ipd_pkg
// Shared types, constants and the digit code table of the IR key decoder.
// ----------------------------------------------------------------------------
package ipd_pkg;

  localparam int TimeW    = 32;
  localparam int ScaledW  = 36;  // ten times a 32-bit interval
  localparam int UnitW    = 24;
  localparam int TolW     = 3;
  localparam int ThrW     = 29;  // 27 * (2^24 - 1) fits
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 24;
  localparam int ByteW    = 8;
  localparam int DigitW   = 4;
  localparam int KeyPairs = 14;

  localparam int FifoDepthDef = 4;

  localparam logic [UnitW-1:0] UnitReset = 24'd12000;
  localparam logic [TolW-1:0]  TolReset  = 3'd1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_UNIT_TICKS = 1'b0,
    REG_TOLERANCE  = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CLS_ZERO  = 2'd0,
    CLS_ONE   = 2'd1,
    CLS_BREAK = 2'd2,
    CLS_LONG  = 2'd3
  } cls_e;

  typedef struct packed {
    logic [ThrW-1:0] lo10;
    logic [ThrW-1:0] hi10;
    logic [ThrW-1:0] lo15;
    logic [ThrW-1:0] hi15;
    logic [ThrW-1:0] lo20;
    logic [ThrW-1:0] hi20;
  } thr_t;

  typedef struct packed {
    logic              found;
    logic [DigitW-1:0] digit;
  } key_t;

  localparam logic [ByteW-1:0] PairFirst [KeyPairs] = '{
    8'h28, 8'h2a, 8'h49, 8'h50, 8'h52, 8'h52, 8'h54,
    8'h56, 8'h56, 8'h58, 8'h5c, 8'hd2, 8'hd6, 8'he8
  };
  localparam logic [ByteW-1:0] PairSecond [KeyPairs] = '{
    8'h13, 8'h49, 8'h2a, 8'h10, 8'h91, 8'h92, 8'h12,
    8'hc8, 8'h93, 8'h18, 8'h1a, 8'h91, 8'h93, 8'h13
  };
  localparam logic [DigitW-1:0] PairDigit [KeyPairs] = '{
    4'd7, 4'd8, 4'd8, 4'd1, 4'd5, 4'd3, 4'd2,
    4'd4, 4'd6, 4'd9, 4'd0, 4'd5, 4'd6, 4'd7
  };

  // lowest table index wins
  function automatic key_t key_lookup(input logic [ByteW-1:0] first,
                                      input logic [ByteW-1:0] second);
    key_t res;
    res.found = 1'b0;
    res.digit = '0;
    for (int i = KeyPairs - 1; i >= 0; i--) begin
      if (PairFirst[i] == first && PairSecond[i] == second) begin
        res.found = 1'b1;
        res.digit = PairDigit[i];
      end
    end
    return res;
  endfunction

endpackage

@@ rtl/core/ipd_edge_if.sv @@
// ----------------------------------------------------------------------------
// ipd_edge_if
// Stream channel carrying falling-edge timestamps.
// ----------------------------------------------------------------------------
interface ipd_edge_if;
  logic                       valid;
  logic                       ready;
  logic [ipd_pkg::TimeW-1:0]  edge_time;

  modport source (output valid, output edge_time, input ready);
  modport sink   (input valid, input edge_time, output ready);
endinterface

@@ rtl/core/ipd_key_if.sv @@
// ----------------------------------------------------------------------------
// ipd_key_if
// Stream channel carrying decoded code bytes and key digits.
// ----------------------------------------------------------------------------
interface ipd_key_if;
  logic                        valid;
  logic                        ready;
  logic [ipd_pkg::ByteW-1:0]   byte_value;
  logic                        key_found;
  logic [ipd_pkg::DigitW-1:0]  key_digit;

  modport source (output valid, output byte_value, output key_found, output key_digit,
                  input ready);
  modport sink   (input valid, input byte_value, input key_found, input key_digit,
                  output ready);
endinterface

@@ rtl/core/ir_pulse_distance_key_decoder.sv @@
// ----------------------------------------------------------------------------
// ir_pulse_distance_key_decoder
// IR remote pulse-distance decoder: edge timestamps in, code bytes and key
// digits out.
// ----------------------------------------------------------------------------
// channel   dir  handshake     payload
// edge_in   in   valid/ready   edge_time[31:0]
// key_out   out  valid/ready   byte_value[7:0], key_found, key_digit[3:0]
// cfg       in   cfg_we_i      cfg_idx_i (0 unit_ticks, 1 tolerance_tenths), cfg_wdata_i
//
// one edge per cycle while the classify stage is not stalled; a result passes the classify stage
// and the class queue into the output register after its edge transfer
// window bounds are registered again from the configuration registers after a write
// reset clears the skip flag, timestamp, code and pair state; no clearing pass
// a stalled output only stops long intervals; zero and one bits keep draining,
// and the intake stops once the class queue is full
// ----------------------------------------------------------------------------
module ir_pulse_distance_key_decoder #(
  parameter int FifoDepth = ipd_pkg::FifoDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ipd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ipd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  ipd_edge_if.sink                      edge_in,
  ipd_key_if.source                     key_out
);
  import ipd_pkg::*;

  logic push_valid, push_ready, pop_valid, pop_ready;
  cls_e push_data, pop_data;

  ipd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .edge_in      (edge_in),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  ipd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  ipd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .key_out     (key_out)
  );

endmodule

@@ rtl/core/ipd_front.sv @@
// ----------------------------------------------------------------------------
// ipd_front
// Edge intake: skips every other edge, measures the interval on the
// down-counting timer and classifies it against the unit windows.
// ----------------------------------------------------------------------------
module ipd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ipd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ipd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  ipd_edge_if.sink                      edge_in,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output ipd_pkg::cls_e                 push_data_o
);
  import ipd_pkg::*;

  logic [UnitW-1:0]   unit_q;
  logic [TolW-1:0]    tol_q;
  thr_t               thr_d, thr_q;
  logic               skip_q;
  logic [TimeW-1:0]   last_q;
  logic               s1_valid_q;
  logic [ScaledW-1:0] s1_scaled_d, s1_scaled_q;

  logic [ThrW-1:0]    ut, u10, u15, u20, ux;
  logic [TimeW-1:0]   diff, interval;
  logic               acc, s1_done, in10, in15, in20;
  cls_e               cls;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q <= UnitReset;
      tol_q  <= TolReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_UNIT_TICKS: unit_q <= cfg_wdata_i[UnitW-1:0];
        REG_TOLERANCE:  tol_q  <= cfg_wdata_i[TolW-1:0];
        default: ;
      endcase
    end
  end

  // window bounds (c -/+ t) * unit, refreshed every cycle
  always_comb begin
    ux  = ThrW'(unit_q);
    ut  = ux * ThrW'(tol_q);
    u10 = (ux << 3) + (ux << 1);
    u15 = (ux << 4) - ux;
    u20 = u10 << 1;
    thr_d.lo10 = u10 - ut;
    thr_d.hi10 = u10 + ut;
    thr_d.lo15 = u15 - ut;
    thr_d.hi15 = u15 + ut;
    thr_d.lo20 = u20 - ut;
    thr_d.hi20 = u20 + ut;
  end

  always_ff @(posedge clk_i) begin
    thr_q <= thr_d;
  end

  // interval with timer wrap
  always_comb begin
    diff        = last_q - edge_in.edge_time;
    interval    = (edge_in.edge_time < last_q) ? diff : diff - TimeW'(1);
    s1_scaled_d = (ScaledW'(interval) << 3) + (ScaledW'(interval) << 1);
  end

  always_comb begin
    in10 = (s1_scaled_q > ScaledW'(thr_q.lo10)) && (s1_scaled_q < ScaledW'(thr_q.hi10));
    in15 = (s1_scaled_q > ScaledW'(thr_q.lo15)) && (s1_scaled_q < ScaledW'(thr_q.hi15));
    in20 = (s1_scaled_q > ScaledW'(thr_q.lo20)) && (s1_scaled_q < ScaledW'(thr_q.hi20));
    if (in10)      cls = CLS_ZERO;
    else if (in15) cls = CLS_ONE;
    else if (in20) cls = CLS_BREAK;
    else           cls = CLS_LONG;
  end

  // breaks are dropped here and never take a queue slot
  assign push_valid_o  = s1_valid_q && (cls != CLS_BREAK);
  assign push_data_o   = cls;
  assign s1_done       = s1_valid_q && ((cls == CLS_BREAK) || push_ready_i);
  assign edge_in.ready = !s1_valid_q || s1_done;
  assign acc           = edge_in.valid && edge_in.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q     <= 1'b0;
      last_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        skip_q <= !skip_q;
        if (!skip_q) begin
          last_q <= edge_in.edge_time;
        end
      end
      if (acc && !skip_q) begin
        s1_valid_q <= 1'b1;
      end else if (s1_done) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && !skip_q) begin
      s1_scaled_q <= s1_scaled_d;
    end
  end

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_done |=> s1_valid_q && $stable(s1_scaled_q))
    else $error("classify stage lost its interval while stalled");

  a_skip_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> skip_q != $past(skip_q))
    else $error("skip flag did not toggle on a transfer");

  a_skip_keeps_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && skip_q |=> $stable(last_q))
    else $error("skipped edge changed the stored timestamp");

endmodule

@@ rtl/core/ipd_fifo.sv @@
// ----------------------------------------------------------------------------
// ipd_fifo
// Small class queue between the edge intake and the byte assembler.
// ----------------------------------------------------------------------------
module ipd_fifo #(
  parameter int Depth = ipd_pkg::FifoDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  ipd_pkg::cls_e  push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output ipd_pkg::cls_e  pop_data_o
);
  import ipd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cls_e            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] count_q;
  logic            push_fire, pop_fire;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push_fire    = push_valid_i && push_ready_o;
  assign pop_fire     = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_fire) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_fire) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_fire && !pop_fire) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_fire && !push_fire) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_fire && !pop_fire |=> count_q == $past(count_q) + CntW'(1))
    else $error("queue count did not follow a push");

  a_empty_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_fire && count_q == '0 |=> pop_valid_o && pop_data_o == $past(push_data_i))
    else $error("push into empty queue not visible at head");

endmodule

@@ rtl/core/ipd_back.sv @@
// ----------------------------------------------------------------------------
// ipd_back
// Byte assembler: shifts zero and one bits into the code, emits the byte on
// a long interval and matches it with the previous byte against the table.
// ----------------------------------------------------------------------------
module ipd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  output logic           pop_ready_o,
  input  ipd_pkg::cls_e  pop_data_i,
  ipd_key_if.source      key_out
);
  import ipd_pkg::*;

  logic [ByteW-1:0]  shift_q, prev_q, byte_q;
  logic              prev_valid_q, out_valid_q, found_q;
  logic [DigitW-1:0] digit_q;
  logic              is_long, pop_fire, found;
  key_t              hit;

  assign is_long     = (pop_data_i == CLS_LONG);
  assign pop_ready_o = !is_long || !out_valid_q || key_out.ready;
  assign pop_fire    = pop_valid_i && pop_ready_o;

  assign hit   = key_lookup(prev_q, shift_q);
  assign found = prev_valid_q && hit.found;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q      <= '0;
      prev_q       <= '0;
      prev_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (pop_fire) begin
        case (pop_data_i)
          CLS_ZERO: shift_q <= {shift_q[ByteW-2:0], 1'b0};
          CLS_ONE:  shift_q <= {shift_q[ByteW-2:0], 1'b1};
          CLS_LONG: begin
            shift_q <= '0;
            if (found) begin
              prev_valid_q <= 1'b0;
            end else begin
              prev_q       <= shift_q;
              prev_valid_q <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (pop_fire && is_long) begin
        out_valid_q <= 1'b1;
      end else if (key_out.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_fire && is_long) begin
      byte_q  <= shift_q;
      found_q <= found;
      digit_q <= found ? hit.digit : '0;
    end
  end

  assign key_out.valid      = out_valid_q;
  assign key_out.byte_value = byte_q;
  assign key_out.key_found  = found_q;
  assign key_out.key_digit  = digit_q;

  a_long_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_fire && is_long |=> out_valid_q && shift_q == '0)
    else $error("long interval did not emit and clear the code");

  a_match_consumes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_fire && is_long && found |=> !prev_valid_q && found_q)
    else $error("matched pair not consumed");

  a_digit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !found_q |-> digit_q == '0)
    else $error("digit set without a key match");

endmodule
